// ----- src/qmvp_pkg.sv -----
package qmvp_pkg;

  localparam int MAX_VEC_LEN = 64;
  localparam int MAX_ROWS    = 1024;

  localparam int VEC_AW  = $clog2(MAX_VEC_LEN);
  localparam int LEN_W   = $clog2(MAX_VEC_LEN + 1);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int ROWS_W  = $clog2(MAX_ROWS + 1);

  localparam int VAL_W   = 8;
  localparam int OFS_W   = 9;
  localparam int DIFF_W  = 10;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int ACC_W   = 32;
  localparam int VLEN_W  = 7;
  localparam int RCNT_W  = 11;
  localparam int CFG_DW  = 11;
  localparam int CFG_AW  = 2;

  typedef enum logic [CFG_AW-1:0] {
    REG_ACT_ZERO    = 2'd0,
    REG_WEIGHT_ZERO = 2'd1,
    REG_VEC_LEN     = 2'd2,
    REG_ROW_COUNT   = 2'd3
  } cfg_reg_t;

  localparam logic OP_LOAD_VEC = 1'b0;
  localparam logic OP_MATRIX   = 1'b1;

  typedef struct packed {
    logic              op;
    logic signed [7:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] dot;
    logic [9:0]         row_index;
  } out_t;

  typedef struct packed {
    logic signed [OFS_W-1:0] act_zero_offset;
    logic signed [OFS_W-1:0] weight_zero_offset;
    logic [VLEN_W-1:0]       vec_len;
    logic [RCNT_W-1:0]       row_count;
  } cfg_t;

  // one matrix word on its way from the sequencer to the mac pipeline
  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic [ROW_W-1:0]        row;
    logic signed [VAL_W-1:0] value;
  } mac_req_t;

endpackage

// ----- src/qmvp_ram.sv -----
module qmvp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/qmvp_regs.sv -----
module qmvp_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qmvp_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [qmvp_pkg::CFG_DW-1:0]   cfg_data,
  output qmvp_pkg::cfg_t                cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.act_zero_offset    <= '0;
      cfg.weight_zero_offset <= '0;
      cfg.vec_len            <= qmvp_pkg::VLEN_W'(64);
      cfg.row_count          <= qmvp_pkg::RCNT_W'(64);
    end else if (cfg_valid) begin
      unique case (qmvp_pkg::cfg_reg_t'(cfg_index))
        qmvp_pkg::REG_ACT_ZERO:    cfg.act_zero_offset    <= cfg_data[qmvp_pkg::OFS_W-1:0];
        qmvp_pkg::REG_WEIGHT_ZERO: cfg.weight_zero_offset <= cfg_data[qmvp_pkg::OFS_W-1:0];
        qmvp_pkg::REG_VEC_LEN:     cfg.vec_len            <= cfg_data[qmvp_pkg::VLEN_W-1:0];
        qmvp_pkg::REG_ROW_COUNT:   cfg.row_count          <= cfg_data[qmvp_pkg::RCNT_W-1:0];
      endcase
    end
  end

endmodule

// ----- src/qmvp_seq.sv -----
module qmvp_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  qmvp_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  input  qmvp_pkg::in_t                 in_data,
  input  logic                          advance,
  output logic                          in_ready,
  output logic                          vec_we,
  output logic [qmvp_pkg::VEC_AW-1:0]   vec_waddr,
  output logic [qmvp_pkg::VAL_W-1:0]    vec_wdata,
  output logic [qmvp_pkg::VEC_AW-1:0]   vec_raddr,
  output qmvp_pkg::mac_req_t            req
);

  logic [qmvp_pkg::VEC_AW-1:0] write_pos, write_pos_next;
  logic [qmvp_pkg::VEC_AW-1:0] column_pos, column_pos_next;
  logic [qmvp_pkg::ROW_W-1:0]  row_pos, row_pos_next;

  logic [qmvp_pkg::LEN_W-1:0]  len;
  logic [qmvp_pkg::ROWS_W-1:0] rows;
  logic [qmvp_pkg::VEC_AW-1:0] wp, cp;
  logic [qmvp_pkg::ROW_W-1:0]  rp;
  logic [qmvp_pkg::LEN_W-1:0]  wp_inc, cp_inc;
  logic [qmvp_pkg::ROWS_W-1:0] rp_inc;
  logic                        accept, col_last;

  // clamp the configured lengths to 1..max
  always_comb begin
    if (cfg.vec_len == '0) begin
      len = qmvp_pkg::LEN_W'(1);
    end else if (int'(cfg.vec_len) > qmvp_pkg::MAX_VEC_LEN) begin
      len = qmvp_pkg::LEN_W'(qmvp_pkg::MAX_VEC_LEN);
    end else begin
      len = qmvp_pkg::LEN_W'(cfg.vec_len);
    end
    if (cfg.row_count == '0) begin
      rows = qmvp_pkg::ROWS_W'(1);
    end else if (int'(cfg.row_count) > qmvp_pkg::MAX_ROWS) begin
      rows = qmvp_pkg::ROWS_W'(qmvp_pkg::MAX_ROWS);
    end else begin
      rows = qmvp_pkg::ROWS_W'(cfg.row_count);
    end
  end

  assign in_ready = advance;
  assign accept   = in_valid && in_ready;

  // stale positions past a shrunken length restart at zero
  assign wp = (qmvp_pkg::LEN_W'(write_pos) >= len) ? '0 : write_pos;
  assign cp = (qmvp_pkg::LEN_W'(column_pos) >= len) ? '0 : column_pos;
  assign rp = (qmvp_pkg::ROWS_W'(row_pos) >= rows) ? '0 : row_pos;

  assign wp_inc   = qmvp_pkg::LEN_W'(wp) + qmvp_pkg::LEN_W'(1);
  assign cp_inc   = qmvp_pkg::LEN_W'(cp) + qmvp_pkg::LEN_W'(1);
  assign rp_inc   = qmvp_pkg::ROWS_W'(rp) + qmvp_pkg::ROWS_W'(1);
  assign col_last = cp_inc >= len;

  always_comb begin
    write_pos_next  = write_pos;
    column_pos_next = column_pos;
    row_pos_next    = row_pos;
    if (accept) begin
      if (in_data.op == qmvp_pkg::OP_LOAD_VEC) begin
        write_pos_next = (wp_inc >= len) ? '0 : wp_inc[qmvp_pkg::VEC_AW-1:0];
      end else begin
        column_pos_next = col_last ? '0 : cp_inc[qmvp_pkg::VEC_AW-1:0];
        if (col_last) begin
          row_pos_next = (rp_inc >= rows) ? '0 : rp_inc[qmvp_pkg::ROW_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos  <= '0;
      column_pos <= '0;
      row_pos    <= '0;
    end else begin
      write_pos  <= write_pos_next;
      column_pos <= column_pos_next;
      row_pos    <= row_pos_next;
    end
  end

  assign vec_we    = accept && (in_data.op == qmvp_pkg::OP_LOAD_VEC);
  assign vec_waddr = wp;
  assign vec_wdata = in_data.value;
  assign vec_raddr = cp;

  assign req.valid = accept && (in_data.op == qmvp_pkg::OP_MATRIX);
  assign req.last  = col_last;
  assign req.row   = rp;
  assign req.value = in_data.value;

  a_row_end_restarts_column: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.last |=> column_pos == '0)
    else $error("column position not restarted after row end");

  a_load_keeps_row: assert property (@(posedge clk) disable iff (rst)
    vec_we |=> $stable(row_pos) && $stable(column_pos))
    else $error("vector load moved matrix positions");

  a_load_xor_matrix: assert property (@(posedge clk) disable iff (rst)
    !(vec_we && req.valid))
    else $error("one word both loaded and multiplied");

endmodule

// ----- src/qmvp_mac.sv -----
module qmvp_mac (
  input  logic                          clk,
  input  logic                          rst,
  input  qmvp_pkg::cfg_t                cfg,
  input  qmvp_pkg::mac_req_t            req,
  input  logic [qmvp_pkg::VAL_W-1:0]    vec_rdata,
  output logic                          advance,
  output logic                          out_valid,
  input  logic                          out_ready,
  output qmvp_pkg::out_t                out_data
);

  // stage 1: word plus vector element from the ram
  logic                            s1_valid;
  logic                            s1_last;
  logic [qmvp_pkg::ROW_W-1:0]      s1_row;
  logic signed [qmvp_pkg::VAL_W-1:0] s1_value;

  // stage 2: registered product
  logic                            s2_valid;
  logic                            s2_last;
  logic [qmvp_pkg::ROW_W-1:0]      s2_row;
  logic signed [qmvp_pkg::PROD_W-1:0] s2_prod;

  logic [qmvp_pkg::ACC_W-1:0]      acc, acc_next;
  logic [qmvp_pkg::ACC_W-1:0]      sum;
  logic signed [qmvp_pkg::DIFF_W-1:0] a_diff, w_diff;
  logic signed [qmvp_pkg::PROD_W-1:0] prod;
  logic                            emit;

  assign advance = !(s2_valid && s2_last && out_valid && !out_ready);
  assign emit    = advance && s2_valid && s2_last;

  assign a_diff = qmvp_pkg::DIFF_W'($signed(vec_rdata)) -
                  qmvp_pkg::DIFF_W'(cfg.act_zero_offset);
  assign w_diff = qmvp_pkg::DIFF_W'(s1_value) -
                  qmvp_pkg::DIFF_W'(cfg.weight_zero_offset);
  assign prod   = a_diff * w_diff;

  assign sum = acc + {{(qmvp_pkg::ACC_W - qmvp_pkg::PROD_W){s2_prod[qmvp_pkg::PROD_W-1]}},
                      s2_prod};

  always_comb begin
    acc_next = acc;
    if (advance && s2_valid) begin
      acc_next = s2_last ? '0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      acc <= acc_next;
      if (advance) begin
        s1_valid <= req.valid;
        s2_valid <= s1_valid;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_last  <= req.last;
      s1_row   <= req.row;
      s1_value <= req.value;
      s2_last  <= s1_last;
      s2_row   <= s1_row;
      s2_prod  <= prod;
    end
    if (emit) begin
      out_data.dot       <= $signed(sum);
      out_data.row_index <= s2_row;
    end
  end

  a_acc_cleared_after_row: assert property (@(posedge clk) disable iff (rst)
    emit |=> acc == '0)
    else $error("accumulator not cleared after row result");

  a_emit_shows_result: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("row result not presented");

  a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(s2_prod) && $stable(acc) && $stable(s1_valid))
    else $error("pipeline moved during stall");

endmodule

// ----- src/quantized_matrix_vector_product_top.sv -----
// Quantized int8 matrix-vector product. Op 0 words load the activation vector
// into a 64-entry circular store; op 1 words stream the matrix in row-major
// order, and each multiplies (vector element - act_zero_offset) by
// (word - weight_zero_offset) into a wrapping 32-bit accumulator. After
// vec_len matrix words the row's dot product and row number come out.
// Throughput is one word per cycle unless input is held off: vector ram read,
// 10x10 multiply and accumulate each sit in their own register stage. A row
// result passes stage 1 and stage 2 into the output register. Input is held
// off only while a finished row result must enter an output register that is
// still occupied. Configuration writes are taken every cycle and must only
// arrive while the block is idle. Vector entries must be written before use.
module quantized_matrix_vector_product_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  qmvp_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output qmvp_pkg::out_t                out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qmvp_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [qmvp_pkg::CFG_DW-1:0]   cfg_data
);

  qmvp_pkg::cfg_t              cfg;
  qmvp_pkg::mac_req_t          req;
  logic                        advance;
  logic                        vec_we;
  logic [qmvp_pkg::VEC_AW-1:0] vec_waddr, vec_raddr;
  logic [qmvp_pkg::VAL_W-1:0]  vec_wdata, vec_rdata;

  qmvp_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  qmvp_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .advance   (advance),
    .in_ready  (in_ready),
    .vec_we    (vec_we),
    .vec_waddr (vec_waddr),
    .vec_wdata (vec_wdata),
    .vec_raddr (vec_raddr),
    .req       (req)
  );

  qmvp_ram #(
    .WIDTH (qmvp_pkg::VAL_W),
    .DEPTH (qmvp_pkg::MAX_VEC_LEN)
  ) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (vec_waddr),
    .wdata (vec_wdata),
    .re    (advance),
    .raddr (vec_raddr),
    .rdata (vec_rdata)
  );

  qmvp_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .vec_rdata (vec_rdata),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
